[src/csu_pkg.sv]
// shared types, constants and palette lookup for the cga sprite stream unpacker
`timescale 1ns / 1ps

package csu_pkg;

    localparam logic [9:0] WRAP_WIDTH_RST    = 10'd320;
    localparam logic [3:0] SPRITE_MARGIN_RST = 4'd3;
    localparam int unsigned QUEUE_DEPTH      = 2;

    typedef enum logic [1:0] {
        PH_WIDTH  = 2'd0,
        PH_HEIGHT = 2'd1,
        PH_PIXELS = 2'd2
    } t_phase;

    typedef enum logic [0:0] {
        REG_WRAP_WIDTH    = 1'b0,
        REG_SPRITE_MARGIN = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        CMD_MARKER = 1'b0,
        CMD_PIXELS = 1'b1
    } t_cmd_kind;

    // one queue entry: either four pixels of a byte or an empty sprite marker
    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [9:0]  x_base;
        logic [15:0] y;
        logic        sprite_end;
    } t_cmd;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // palette 1, high intensity
    function automatic t_rgb palette(input logic [1:0] code);
        t_rgb c;
        c = '{r: 8'h00, g: 8'h00, b: 8'h00};
        case (code)
            2'd1:    c = '{r: 8'h55, g: 8'hFF, b: 8'hFF};
            2'd2:    c = '{r: 8'hFF, g: 8'h55, b: 8'hFF};
            2'd3:    c = '{r: 8'hFF, g: 8'hFF, b: 8'hFF};
            default: c = '{r: 8'h00, g: 8'h00, b: 8'h00};
        endcase
        return c;
    endfunction

endpackage

[src/cga_sprite_stream_unpacker_top.sv]
// top level of the cga 2bpp sprite stream unpacker with shelf layout
`timescale 1ns / 1ps

// Input channel (i_valid/o_ready, i_data_byte) takes the sprite byte stream:
// width byte, height byte, then height rows of ceil(width/4) packed bytes.
// Output channel (o_valid/i_ready) gives one pixel per item with its screen
// position, color code and palette rgb; last_of_run marks the fourth pixel of
// a byte and the marker item, sprite_end the final item of a sprite. An empty
// sprite gives a single marker item with pixel_valid low.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): index 0
// is the wrap width, index 1 the sprite margin; other indexes are dropped.
// Write it only while the block is idle.
// The first item of a byte passes through the command queue, then the output
// register. Throughput: one output item per cycle while i_ready is high, so
// four items per byte; the single output register that emits one pixel
// a cycle sets this. Width and height bytes are taken when o_ready is high.
// A two-entry command queue lets the parser accept bytes while the output
// side is stalled; when the receiver holds i_ready low the queue fills and
// o_ready drops. Reset restores the register defaults, homes the cursor and
// empties the queue and output register.
module cga_sprite_stream_unpacker_top
    import csu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_pixel_x,
    output logic [15:0] o_pixel_y,
    output logic [1:0]  o_color_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_pixel_valid,
    output logic        o_last_of_run,
    output logic        o_sprite_end
);

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    csu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_queue_full (q_full),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    csu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_cmd       (head_cmd)
    );

    csu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_not_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_color_index (o_color_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_pixel_valid (o_pixel_valid),
        .o_last_of_run (o_last_of_run),
        .o_sprite_end  (o_sprite_end)
    );

endmodule

[src/csu_front.sv]
// front end: config registers, stream parser and shelf layout cursor
`timescale 1ns / 1ps

module csu_front
    import csu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_queue_full,
    output logic        o_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [9:0]  r_wrap_width;
    logic [3:0]  r_margin;
    logic [7:0]  r_sprite_width, n_sprite_width;
    logic [7:0]  r_sprite_height, n_sprite_height;
    logic [7:0]  r_row_count, n_row_count;
    logic [6:0]  r_byte_in_row, n_byte_in_row;
    logic [9:0]  r_origin_x, n_origin_x;
    logic [15:0] r_origin_y, n_origin_y;
    logic [9:0]  r_cursor_x, n_cursor_x;
    logic [15:0] r_cursor_y, n_cursor_y;
    logic [7:0]  r_row_max, n_row_max;

    logic        accept;
    logic        wrap_hit;
    logic [9:0]  cx0;
    logic [15:0] cy0;
    logic [7:0]  rmax0;
    logic [8:0]  padded;
    logic [6:0]  bytes_per_row;
    logic [6:0]  bir_inc;
    logic [7:0]  row_inc;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= WRAP_WIDTH_RST;
            r_margin     <= SPRITE_MARGIN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == {1'b0, REG_WRAP_WIDTH}) begin
                r_wrap_width <= i_cfg_data;
            end else if (i_cfg_index == {1'b0, REG_SPRITE_MARGIN}) begin
                r_margin <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_WIDTH;
            r_sprite_width  <= '0;
            r_sprite_height <= '0;
            r_row_count     <= '0;
            r_byte_in_row   <= '0;
            r_origin_x      <= '0;
            r_origin_y      <= '0;
            r_cursor_x      <= '0;
            r_cursor_y      <= '0;
            r_row_max       <= '0;
        end else begin
            r_phase         <= n_phase;
            r_sprite_width  <= n_sprite_width;
            r_sprite_height <= n_sprite_height;
            r_row_count     <= n_row_count;
            r_byte_in_row   <= n_byte_in_row;
            r_origin_x      <= n_origin_x;
            r_origin_y      <= n_origin_y;
            r_cursor_x      <= n_cursor_x;
            r_cursor_y      <= n_cursor_y;
            r_row_max       <= n_row_max;
        end
    end

    // shelf wrap test and cursor advance
    always_comb begin
        wrap_hit = ({1'b0, r_cursor_x} + {3'b0, r_sprite_width}) > {1'b0, r_wrap_width};
        cx0      = wrap_hit ? 10'd0 : r_cursor_x;
        cy0      = wrap_hit ? 16'(r_cursor_y + {8'b0, r_row_max} + {12'b0, r_margin})
                            : r_cursor_y;
        rmax0    = wrap_hit ? 8'd0 : r_row_max;
        padded   = ({1'b0, r_sprite_width} + 9'd3) & ~9'd3;
        bytes_per_row = 7'(({1'b0, r_sprite_width} + 9'd3) >> 2);
        bir_inc  = r_byte_in_row + 7'd1;
        row_inc  = r_row_count + 8'd1;
    end

    always_comb begin
        n_phase         = r_phase;
        n_sprite_width  = r_sprite_width;
        n_sprite_height = r_sprite_height;
        n_row_count     = r_row_count;
        n_byte_in_row   = r_byte_in_row;
        n_origin_x      = r_origin_x;
        n_origin_y      = r_origin_y;
        n_cursor_x      = r_cursor_x;
        n_cursor_y      = r_cursor_y;
        n_row_max       = r_row_max;
        o_push          = 1'b0;
        o_cmd.kind       = CMD_PIXELS;
        o_cmd.data       = i_data_byte;
        o_cmd.x_base     = 10'(r_origin_x + {1'b0, r_byte_in_row, 2'b00});
        o_cmd.y          = 16'(r_origin_y + {8'b0, r_row_count});
        o_cmd.sprite_end = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_HEIGHT: begin
                    n_sprite_height = i_data_byte;
                    n_origin_x      = cx0;
                    n_origin_y      = cy0;
                    n_cursor_y      = cy0;
                    n_row_max       = (i_data_byte > rmax0) ? i_data_byte : rmax0;
                    n_cursor_x      = 10'({1'b0, cx0} + {2'b0, padded} + {7'b0, r_margin});
                    n_row_count     = '0;
                    n_byte_in_row   = '0;
                    if (r_sprite_width == 8'd0 || i_data_byte == 8'd0) begin
                        n_phase          = PH_WIDTH;
                        o_push           = 1'b1;
                        o_cmd.kind       = CMD_MARKER;
                        o_cmd.x_base     = cx0;
                        o_cmd.y          = cy0;
                        o_cmd.sprite_end = 1'b1;
                    end else begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    o_push        = 1'b1;
                    n_byte_in_row = bir_inc;
                    if (bir_inc >= bytes_per_row) begin
                        n_byte_in_row = '0;
                        n_row_count   = row_inc;
                        if (row_inc >= r_sprite_height) begin
                            o_cmd.sprite_end = 1'b1;
                            n_phase          = PH_WIDTH;
                        end
                    end
                end
                default: begin
                    // width byte, also taken for the unused phase code
                    n_sprite_width = i_data_byte;
                    n_phase        = PH_HEIGHT;
                end
            endcase
        end
    end

endmodule

[src/csu_queue.sv]
// two-entry command queue between the parser and the pixel expander
`timescale 1ns / 1ps

module csu_queue
    import csu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_not_empty,
    output t_cmd o_cmd
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full      = (r_count == CntW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/csu_back.sv]
// back end: expands queued commands into pixel results in an output register
`timescale 1ns / 1ps

module csu_back
    import csu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [9:0]  o_pixel_x,
    output logic [15:0] o_pixel_y,
    output logic [1:0]  o_color_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_pixel_valid,
    output logic        o_last_of_run,
    output logic        o_sprite_end
);

    logic        r_valid;
    logic [1:0]  r_sub;
    logic [9:0]  r_x;
    logic [15:0] r_y;
    logic [1:0]  r_color;
    t_rgb        r_rgb;
    logic        r_pix;
    logic        r_last;
    logic        r_end;

    logic        load;
    logic        is_pix;
    logic [1:0]  code;
    logic [9:0]  x_next;
    logic        sub_last;

    assign load     = i_cmd_valid && (!r_valid || i_ready);
    assign is_pix   = (i_cmd.kind == CMD_PIXELS);
    // bits 1:0 come first and sit at the rightmost column of the group
    assign code     = 2'(i_cmd.data >> {r_sub, 1'b0});
    assign x_next   = is_pix ? 10'(i_cmd.x_base + {8'b0, 2'd3 - r_sub}) : i_cmd.x_base;
    assign sub_last = !is_pix || (r_sub == 2'd3);
    assign o_pop    = load && sub_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= sub_last ? 2'd0 : r_sub + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x     <= x_next;
            r_y     <= i_cmd.y;
            r_color <= is_pix ? code : 2'd0;
            r_rgb   <= is_pix ? palette(code) : '0;
            r_pix   <= is_pix;
            r_last  <= sub_last;
            r_end   <= sub_last && i_cmd.sprite_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_x     = r_x;
    assign o_pixel_y     = r_y;
    assign o_color_index = r_color;
    assign o_red         = r_rgb.r;
    assign o_green       = r_rgb.g;
    assign o_blue        = r_rgb.b;
    assign o_pixel_valid = r_pix;
    assign o_last_of_run = r_last;
    assign o_sprite_end  = r_end;

endmodule
